/* rtl/lbt_pkg.sv */
package lbt_pkg;

  // Table depth default and fixed field widths
  localparam int unsigned MaxEntries = 128;
  localparam int unsigned ActW       = 2;
  localparam int unsigned LineW      = 20;
  localparam int unsigned IdW        = 7;
  localparam int unsigned StatW      = 2;
  localparam int unsigned IdxW       = 7;

  typedef enum logic [ActW-1:0] {
    ACT_SET    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_NONE = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/lbt_if.sv */
interface lbt_req_if;
  logic                          valid;
  logic                          ready;
  logic [lbt_pkg::ActW-1:0]      action;
  logic [lbt_pkg::LineW-1:0]     line;
  logic [lbt_pkg::IdW-1:0]       entry_id;

  modport source (output valid, action, line, entry_id, input ready);
  modport sink   (input valid, action, line, entry_id, output ready);
endinterface

interface lbt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lbt_pkg::StatW-1:0]     status;
  logic                          hit;
  logic [lbt_pkg::IdxW-1:0]      index;

  modport source (output valid, status, hit, index, input ready);
  modport sink   (input valid, status, hit, index, output ready);
endinterface

/* rtl/lbt_ctrl.sv */
module lbt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  lbt_pkg::dp_stat_t stat_i,
  output lbt_pkg::dp_cmd_t  cmd_o
);
  import lbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Sequence one request: take it, scan the table, then write back and respond
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    req_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/lbt_dp.sv */
module lbt_dp #(
  parameter int unsigned MAX_ENTRIES = lbt_pkg::MaxEntries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbt_pkg::dp_cmd_t            cmd_i,
  output lbt_pkg::dp_stat_t           stat_o,
  input  logic [lbt_pkg::ActW-1:0]    action_i,
  input  logic [lbt_pkg::LineW-1:0]   line_i,
  input  logic [lbt_pkg::IdW-1:0]     entry_id_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output logic [lbt_pkg::StatW-1:0]   status_o,
  output logic                        hit_o,
  output logic [lbt_pkg::IdxW-1:0]    index_o
);
  import lbt_pkg::*;

  localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > IdW) ? CW : IdW;

  // Latched request
  action_e          act_q;
  logic [LineW-1:0] line_q;
  logic [IdW-1:0]   id_q;
  logic             scan_en_q;

  // Table state
  logic [LineW-1:0]       mem_q [MAX_ENTRIES];
  logic [LineW-1:0]       rdata_q;
  logic [MAX_ENTRIES-1:0] en_q;
  logic [MAX_ENTRIES-1:0] re_q;
  logic [CW-1:0]          count_q;

  // Scan pipeline
  logic [CW-1:0] rd_ptr_q;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic          found_q;
  logic [IW-1:0] found_idx_q;

  // Response register
  logic             rsp_valid_q;
  status_e          rsp_status_q;
  logic             rsp_hit_q;
  logic [IdxW-1:0]  rsp_index_q;

  logic          full;
  logic          issue;
  logic          hit_now;
  logic [IW-1:0] id_idx;
  logic          id_ok;
  logic [IW-1:0] new_idx;

  status_e         res_status;
  logic            res_hit;
  logic [IdxW-1:0] res_index;
  logic            wr_new;
  logic            wr_reached;
  logic            wr_disable;
  logic            wr_clear;

  assign full    = (count_q >= CW'(MAX_ENTRIES));
  assign new_idx = count_q[IW-1:0];
  assign id_idx  = IW'(id_q);
  assign id_ok   = (CMPW'(id_q) < CMPW'(count_q)) && en_q[id_idx];

  // Compare the entry read in the previous cycle against the line
  assign hit_now = cmd_i.scan && cmp_vld_q && en_q[cmp_idx_q] && !re_q[cmp_idx_q] &&
                   (rdata_q == line_q);
  assign issue   = cmd_i.scan && scan_en_q && !found_q && !hit_now && (rd_ptr_q < count_q);

  assign stat_o.scan_done = !scan_en_q || found_q || (!cmp_vld_q && (rd_ptr_q >= count_q));
  assign stat_o.out_free  = !rsp_valid_q || rsp_ready_i;

  // Decide the outcome and the table updates of the current request
  always_comb begin
    res_status = ST_OK;
    res_hit    = 1'b0;
    res_index  = '0;
    wr_new     = 1'b0;
    wr_reached = 1'b0;
    wr_disable = 1'b0;
    wr_clear   = 1'b0;
    case (act_q)
      ACT_SET: begin
        if (full) begin
          res_status = ST_FULL;
        end else if (found_q) begin
          res_status = ST_DUP;
          res_index  = IdxW'(found_idx_q);
          wr_reached = 1'b1;
        end else begin
          res_index  = IdxW'(new_idx);
          wr_new     = 1'b1;
        end
      end
      ACT_DELETE: begin
        res_index = id_q;
        if (id_ok) begin
          wr_disable = 1'b1;
        end else begin
          res_status = ST_NONE;
        end
      end
      ACT_CHECK: begin
        if (found_q) begin
          res_hit    = 1'b1;
          res_index  = IdxW'(found_idx_q);
          wr_reached = 1'b1;
        end
      end
      ACT_CLEAR: begin
        wr_clear = 1'b1;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(action_i);
      line_q <= line_i;
      id_q   <= entry_id_i;
    end
  end

  // Line store: one write port at commit, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_new) begin
      mem_q[new_idx] <= line_q;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_ptr_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_idx_q <= rd_ptr_q[IW-1:0];
    end
    if (hit_now) begin
      found_idx_q <= cmp_idx_q;
    end
  end

  // Advance the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_en_q <= 1'b0;
      rd_ptr_q  <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else if (cmd_i.load) begin
      scan_en_q <= (action_e'(action_i) == ACT_CHECK) ||
                   ((action_e'(action_i) == ACT_SET) && !full);
      rd_ptr_q  <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      cmp_vld_q <= issue;
      if (issue) begin
        rd_ptr_q <= rd_ptr_q + CW'(1);
      end
      if (hit_now) begin
        found_q <= 1'b1;
      end
    end
  end

  // Entry marks and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= '0;
      re_q    <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      if (wr_new) begin
        en_q[new_idx] <= 1'b1;
        re_q[new_idx] <= 1'b0;
        count_q       <= count_q + CW'(1);
      end
      if (wr_reached) begin
        re_q[found_idx_q] <= 1'b1;
      end
      if (wr_disable) begin
        en_q[id_idx] <= 1'b0;
      end
      if (wr_clear) begin
        re_q <= '0;
      end
    end
  end

  // Response register: load on commit, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_status_q <= res_status;
      rsp_hit_q    <= res_hit;
      rsp_index_q  <= res_index;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign status_o    = rsp_status_q;
  assign hit_o       = rsp_hit_q;
  assign index_o     = rsp_index_q;

endmodule

/* rtl/line_breakpoint_table.sv */
// Channel   Dir  Signals                                   Transfer
// req_i     in   valid, ready, action, line, entry_id      valid && ready
// rsp_o     out  valid, ready, status, hit, index          valid && ready
//
// One request at a time. Set and check scan the used entries one per cycle
// through the line store's read port and stop at a match. On an empty table,
// and for a set on a full table, there is no scan. Delete and clear do not
// scan.
// Exactly one response per request.
// Reset clears the entry marks and the fill count; the line store keeps no reset.
// A stalled response holds in its register; the next request is taken meanwhile
// and waits before its write-back until that response transfers.
module line_breakpoint_table #(
  parameter int unsigned MAX_ENTRIES = lbt_pkg::MaxEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  lbt_req_if.sink         req_i,
  lbt_rsp_if.source       rsp_o
);
  import lbt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lbt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .action_i    (req_i.action),
    .line_i      (req_i.line),
    .entry_id_i  (req_i.entry_id),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_o    (rsp_o.status),
    .hit_o       (rsp_o.hit),
    .index_o     (rsp_o.index)
  );

endmodule

/* rtl/lbt_checker.sv */
module lbt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [lbt_pkg::StatW-1:0]   rsp_status_i,
  input logic                        rsp_hit_i,
  input logic [lbt_pkg::IdxW-1:0]    rsp_index_i
);
  import lbt_pkg::*;

  // A stalled response holds its contents
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
    $stable(rsp_hit_i) && $stable(rsp_index_i))
    else $error("response changed while stalled");

  // One request at a time: ready drops after a transfer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // A hit only comes with an ok status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_hit_i |-> rsp_status_i == ST_OK)
    else $error("hit reported with an error status");

  // A full table reports neither hit nor index
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |-> !rsp_hit_i && rsp_index_i == '0)
    else $error("table full response carries a hit or index");

endmodule

bind line_breakpoint_table lbt_checker u_lbt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_hit_i    (rsp_o.hit),
  .rsp_index_i  (rsp_o.index)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import lbt_pkg::*;

  localparam int unsigned RandItems  = 1800;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned PoolSize   = 16;

  typedef struct packed {
    status_e             status;
    logic                hit;
    logic [IdxW-1:0]     index;
  } bp_result_t;

  typedef struct packed {
    action_e             act;
    logic [LineW-1:0]    ln;
    logic [IdW-1:0]      id;
    logic                typed;
    bp_result_t          res;
  } bp_row_t;

  // Directed rows; typed results only where they are obvious
  localparam bp_row_t DirectedRows [19] = '{
    '{ACT_CHECK,  20'h00000, 7'd0,   1'b1, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_DELETE, 20'h00000, 7'd0,   1'b1, '{ST_NONE, 1'b0, 7'd0}},
    '{ACT_DELETE, 20'h00000, 7'd127, 1'b1, '{ST_NONE, 1'b0, 7'd127}},
    '{ACT_CLEAR,  20'h00000, 7'd0,   1'b1, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_SET,    20'h00000, 7'd0,   1'b1, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_SET,    20'hFFFFF, 7'd0,   1'b1, '{ST_OK,   1'b0, 7'd1}},
    '{ACT_SET,    20'h00000, 7'd0,   1'b1, '{ST_DUP,  1'b0, 7'd0}},
    '{ACT_SET,    20'h00000, 7'd0,   1'b0, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_CHECK,  20'h00000, 7'd0,   1'b0, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_CHECK,  20'h00000, 7'd0,   1'b0, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_CLEAR,  20'h00000, 7'd0,   1'b1, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_CHECK,  20'h00000, 7'd0,   1'b0, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_DELETE, 20'h00000, 7'd0,   1'b1, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_DELETE, 20'h00000, 7'd0,   1'b1, '{ST_NONE, 1'b0, 7'd0}},
    '{ACT_DELETE, 20'h00000, 7'd3,   1'b1, '{ST_NONE, 1'b0, 7'd3}},
    '{ACT_CHECK,  20'hFFFFF, 7'd0,   1'b0, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_SET,    20'h00000, 7'd0,   1'b0, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_SET,    20'hA5A5A, 7'h55,  1'b0, '{ST_OK,   1'b0, 7'd0}},
    '{ACT_CHECK,  20'h5A5A5, 7'h2A,  1'b0, '{ST_OK,   1'b0, 7'd0}}
  };

  logic clk_i;
  logic rst_ni;

  lbt_req_if req ();
  lbt_rsp_if rsp ();

  line_breakpoint_table #(
    .MAX_ENTRIES(MaxEntries)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Shadow copy of the breakpoint table
  logic [LineW-1:0] bp_line    [MaxEntries];
  logic             bp_enabled [MaxEntries];
  logic             bp_reached [MaxEntries];
  int unsigned      bp_fill;

  bp_result_t       pending_rsp[$];
  logic [LineW-1:0] line_pool [PoolSize];

  int unsigned cycles;
  int unsigned fails;
  int unsigned n_req, n_hit, n_dup, n_full, n_none;
  int unsigned stall_left;
  bit          calm;
  bit          quiet;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Find the first live, unreached entry on a line and mark it reached
  function automatic int claim_line(logic [LineW-1:0] ln);
    for (int i = 0; i < bp_fill; i++) begin
      if (bp_enabled[i] && !bp_reached[i] && bp_line[i] == ln) begin
        bp_reached[i] = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return its response
  function automatic bp_result_t table_response(action_e act, logic [LineW-1:0] ln,
                                                logic [IdW-1:0] id);
    bp_result_t r;
    int         found;
    r = '{ST_OK, 1'b0, '0};
    case (act)
      ACT_SET: begin
        if (bp_fill >= MaxEntries) begin
          r.status = ST_FULL;
        end else begin
          found = claim_line(ln);
          if (found >= 0) begin
            r.status = ST_DUP;
            r.index  = IdxW'(found);
          end else begin
            bp_line[bp_fill]    = ln;
            bp_enabled[bp_fill] = 1'b1;
            bp_reached[bp_fill] = 1'b0;
            r.index             = IdxW'(bp_fill);
            bp_fill++;
          end
        end
      end
      ACT_DELETE: begin
        r.index = id;
        if (id < bp_fill && bp_enabled[id]) begin
          bp_enabled[id] = 1'b0;
        end else begin
          r.status = ST_NONE;
        end
      end
      ACT_CHECK: begin
        found = claim_line(ln);
        if (found >= 0) begin
          r.hit   = 1'b1;
          r.index = IdxW'(found);
        end
      end
      default: begin
        for (int i = 0; i < MaxEntries; i++) bp_reached[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Hold a request until it transfers, then log its response and maybe pause
  task automatic issue(action_e act, logic [LineW-1:0] ln, logic [IdW-1:0] id,
                       logic typed, bp_result_t typed_res);
    bp_result_t r;
    req.valid    <= 1'b1;
    req.action   <= act;
    req.line     <= ln;
    req.entry_id <= id;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    r = table_response(act, ln, id);
    if (typed) r = typed_res;
    pending_rsp.push_back(r);
    n_req++;
    if (r.hit) n_hit++;
    if (r.status == ST_DUP) n_dup++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_NONE) n_none++;
    if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Compare each response transfer, then drive ready with random stall bursts
  always @(posedge clk_i) begin
    bp_result_t want;
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing pending: status %0d hit %0d index %0d",
               rsp.status, rsp.hit, rsp.index);
        fails++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          fails++;
        end
        if (rsp.hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
          fails++;
        end
        if (rsp.index !== want.index) begin
          $error("index: expected %0d, actual %0d", want.index, rsp.index);
          fails++;
        end
      end
    end
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (quiet || calm) begin
      stall_left = 0;
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= (stall_left == 0);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses pending", cycles,
               pending_rsp.size());
      $display("line_breakpoint_table: mismatch");
      $finish;
    end
  end

  initial begin
    action_e          act;
    logic [LineW-1:0] ln;
    logic [IdW-1:0]   id;
    logic [31:0]      rnd;
    int unsigned      pick;
    int unsigned      p_set;
    int unsigned      p_del;

    rst_ni       <= 1'b0;
    req.valid    <= 1'b0;
    req.action   <= ACT_SET;
    req.line     <= '0;
    req.entry_id <= '0;
    n_req      = 0;
    n_hit      = 0;
    n_dup      = 0;
    n_full     = 0;
    n_none     = 0;
    calm       = 1'b0;
    quiet      = 1'b0;
    bp_fill    = 0;
    for (int i = 0; i < MaxEntries; i++) begin
      bp_line[i]    = '0;
      bp_enabled[i] = 1'b0;
      bp_reached[i] = 1'b0;
    end

    // Small set of recurring lines so sets collide and checks hit
    line_pool[0] = '0;
    line_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) begin
      rnd          = $urandom;
      line_pool[i] = rnd[LineW-1:0];
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk
    foreach (DirectedRows[k]) begin
      issue(DirectedRows[k].act, DirectedRows[k].ln, DirectedRows[k].id,
            DirectedRows[k].typed, DirectedRows[k].res);
    end

    // Random traffic; sets get denser later so the table fills up
    for (int n = 0; n < RandItems; n++) begin
      calm  = (n % 300) >= 240;
      quiet = n >= RandItems - 120;
      rnd   = $urandom;
      ln    = rnd[LineW-1:0];
      rnd   = $urandom;
      id    = rnd[IdW-1:0];
      p_set = (n < 900) ? 15 : 35;
      p_del = (n < 900) ? 15 : 8;
      pick  = $urandom_range(0, 99);
      if (pick < p_set) begin
        act = ACT_SET;
        if ($urandom_range(0, 1) == 0) ln = line_pool[$urandom_range(0, PoolSize - 1)];
      end else if (pick < p_set + p_del) begin
        act = ACT_DELETE;
        if (bp_fill > 0 && $urandom_range(0, 9) < 6) id = IdW'($urandom_range(0, bp_fill - 1));
      end else if (pick < p_set + p_del + 5) begin
        act = ACT_CLEAR;
      end else begin
        act = ACT_CHECK;
        if ($urandom_range(0, 99) < 85) ln = line_pool[$urandom_range(0, PoolSize - 1)];
      end
      issue(act, ln, id, 1'b0, '{ST_OK, 1'b0, '0});
    end
    req.valid <= 1'b0;

    // Drain, then give the block time to show any stray response
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (MaxEntries + 8) @(posedge clk_i);

    $display("%0d requests, %0d check hits, %0d duplicate sets, %0d full-table sets,",
             n_req, n_hit, n_dup, n_full);
    $display("%0d rejected deletes; %0d of %0d entries used", n_none, bp_fill, MaxEntries);
    if (fails == 0) begin
      $display("line_breakpoint_table: match");
    end else begin
      $display("line_breakpoint_table: mismatch");
    end
    $finish;
  end

endmodule
